FILE: hw/rtl/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg: shared types and constants of the scheduler queues
// Operation codes, sequencer states, comparator result and queue control.
// ----------------------------------------------------------------------------
package prs_pkg;

  // Width of a thread identifier.
  localparam int IdW = 4;

  // Slice register reset and saturation value.
  localparam logic [7:0] SliceReset = 8'd4;
  localparam logic [7:0] SliceMax   = 8'd255;

  // Operation codes carried by an input word.
  typedef enum logic [1:0] {
    OP_READY    = 2'd0,
    OP_SLEEP    = 2'd1,
    OP_TICK     = 2'd2,
    OP_DISPATCH = 2'd3
  } op_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RSCAN,
    ST_SSCAN,
    ST_WAKE,
    ST_DONE
  } state_t;

  // Outputs of the shared comparator.
  typedef struct packed {
    logic tick_lt;
    logic tick_eq;
    logic prio_ge;
  } cmp_res_t;

  // Control of one ordered queue.
  typedef struct packed {
    logic ins_en;
    logic pop_en;
  } q_ctrl_t;

endpackage

FILE: hw/rtl/prs_cmp.sv
// ----------------------------------------------------------------------------
// prs_cmp: shared compare unit
// One tick comparator and one priority comparator used by every scan step.
// ----------------------------------------------------------------------------
module prs_cmp #(
  parameter int TICK_BITS     = 32,
  parameter int PRIORITY_BITS = 6
) (
  input  logic [TICK_BITS-1:0]     tick_a,
  input  logic [TICK_BITS-1:0]     tick_b,
  input  logic [PRIORITY_BITS-1:0] prio_a,
  input  logic [PRIORITY_BITS-1:0] prio_b,
  output prs_pkg::cmp_res_t        res
);
  import prs_pkg::*;

  // Unsigned compares of both operand pairs.
  always_comb begin
    res.tick_lt = tick_a < tick_b;
    res.tick_eq = tick_a == tick_b;
    res.prio_ge = prio_a >= prio_b;
  end

endmodule

FILE: hw/rtl/prs_shq.sv
// ----------------------------------------------------------------------------
// prs_shq: ordered shift queue
// Entries shift up on an insert at a given place and down on a pop of the
// front; one entry can be read at a scan index.
// ----------------------------------------------------------------------------
module prs_shq #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16,
  localparam int IdxW = $clog2(DEPTH),
  localparam int CntW = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  prs_pkg::q_ctrl_t      ctrl,
  input  logic [IdxW-1:0]       ins_pos,
  input  logic [WIDTH-1:0]      ins_data,
  input  logic [IdxW-1:0]       rd_idx,
  output logic [WIDTH-1:0]      rd_data,
  output logic [WIDTH-1:0]      front,
  output logic [CntW-1:0]       count
);
  import prs_pkg::*;

  logic [WIDTH-1:0] entries [DEPTH];

  assign rd_data = entries[rd_idx];
  assign front   = entries[0];

  // Entry storage: each entry takes its neighbour on a shift.
  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (ctrl.ins_en) begin
        if (IdxW'(i) == ins_pos) begin
          entries[i] <= ins_data;
        end else if (IdxW'(i) > ins_pos && i > 0) begin
          entries[i] <= entries[(i > 0) ? i - 1 : 0];
        end
      end else if (ctrl.pop_en && i < DEPTH - 1) begin
        entries[i] <= entries[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.ins_en) begin
      count <= count + CntW'(1);
    end else if (ctrl.pop_en) begin
      count <= count - CntW'(1);
    end
  end

endmodule

FILE: hw/rtl/priority_ready_and_sleep_queues_top.sv
// ----------------------------------------------------------------------------
// priority_ready_and_sleep_queues_top: thread scheduler queues
// A priority ordered ready queue and a wake tick ordered sleep queue under a
// small sequencer that shares one compare unit.
// ----------------------------------------------------------------------------
// Usage: every word on the slave stream carries op, thread_id, priority_req,
// wake_tick and now_tick; every word yields exactly one result word on the
// master stream (next_thread, dispatch_valid, preempt, woke_count, status).
// The time slice register is written through cfg_we and cfg_wdata.
// Steps: a dispatch and an insert into a full queue go straight to the final
// state. An insert walks past the entries ahead of its place in its queue
// (fewer than MAX_THREADS). A tick checks the front of the sleep queue and
// gives every woken sleeper an ordered insert into the ready queue. The
// scan walks one entry a cycle through the single compare unit.
// s_tready is high only while the sequencer is idle; one word is worked on
// at a time. The result sits in an output register, so the next word is
// taken while a result waits; a stalled receiver holds the sequencer in its
// final state once that register is full.
// Reset empties both queues, clears the slice count and sets time slice to 4.
// ----------------------------------------------------------------------------
module priority_ready_and_sleep_queues_top #(
  parameter int MAX_THREADS   = 16,
  parameter int PRIORITY_BITS = 6,
  parameter int TICK_BITS     = 32,
  localparam int InW  = 6 + PRIORITY_BITS + 2 * TICK_BITS,
  localparam int InPW = ((InW + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst,
  // Slave word, from bit 0: op, thread_id, priority_req, wake_tick, now_tick.
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [InPW-1:0] s_tdata,
  // Master word, from bit 0: next_thread, dispatch_valid, preempt,
  // woke_count, status.
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [15:0]     m_tdata,
  input  logic            cfg_we,
  input  logic [7:0]      cfg_wdata
);
  import prs_pkg::*;

  localparam int IdxW = $clog2(MAX_THREADS);
  localparam int CntW = $clog2(MAX_THREADS + 1);
  localparam int RW   = IdW + PRIORITY_BITS;
  localparam int SW   = TICK_BITS + PRIORITY_BITS + IdW;
  localparam int PL   = 6;
  localparam int WL   = 6 + PRIORITY_BITS;
  localparam int NL   = WL + TICK_BITS;

  // Input fields.
  op_t                    in_op;
  logic [IdW-1:0]         in_id;
  logic [PRIORITY_BITS-1:0] in_prio;
  logic [TICK_BITS-1:0]   in_wake;
  logic [TICK_BITS-1:0]   in_now;

  assign in_op   = op_t'(s_tdata[1:0]);
  assign in_id   = s_tdata[5:2];
  assign in_prio = s_tdata[PL+PRIORITY_BITS-1:PL];
  assign in_wake = s_tdata[WL+TICK_BITS-1:WL];
  assign in_now  = s_tdata[NL+TICK_BITS-1:NL];

  state_t                 state, state_next;
  logic                   waking;
  logic [IdW-1:0]         cur_id;
  logic [PRIORITY_BITS-1:0] cur_prio;
  logic [TICK_BITS-1:0]   cur_wake;
  logic [TICK_BITS-1:0]   now_r;
  logic [IdxW-1:0]        idx;
  logic [7:0]             slice_limit;
  logic [7:0]             slice;
  logic [7:0]             slice_inc;
  logic [3:0]             res_next;
  logic                   res_valid;
  logic                   res_preempt;
  logic [CntW-1:0]        woke;
  logic                   res_status;
  logic                   out_valid;
  logic [15:0]            out_data;

  logic                   accept;
  logic                   out_load;
  q_ctrl_t                rq_ctrl, sq_ctrl;
  logic [RW-1:0]          rq_rd, rq_front;
  logic [SW-1:0]          sq_rd, sq_front;
  logic [CntW-1:0]        rq_count, sq_count;
  logic                   rq_full, sq_full;
  logic                   scan_more;
  logic                   wake_due;

  logic [TICK_BITS-1:0]     cmp_ta, cmp_tb;
  logic [PRIORITY_BITS-1:0] cmp_pa, cmp_pb;
  cmp_res_t                 cmp;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = state == ST_IDLE && !rst;
  assign out_load = state == ST_DONE && (!out_valid || m_tready);
  assign rq_full  = rq_count == CntW'(MAX_THREADS);
  assign sq_full  = sq_count == CntW'(MAX_THREADS);
  assign slice_inc = (slice != SliceMax) ? slice + 8'd1 : slice;
  assign wake_due = sq_count != '0 && (cmp.tick_lt || cmp.tick_eq) && !rq_full;

  // Queues.
  prs_shq #(.WIDTH(RW), .DEPTH(MAX_THREADS)) u_ready (
    .clk(clk), .rst(rst), .ctrl(rq_ctrl), .ins_pos(idx),
    .ins_data({cur_id, cur_prio}), .rd_idx(idx),
    .rd_data(rq_rd), .front(rq_front), .count(rq_count)
  );

  prs_shq #(.WIDTH(SW), .DEPTH(MAX_THREADS)) u_sleep (
    .clk(clk), .rst(rst), .ctrl(sq_ctrl), .ins_pos(idx),
    .ins_data({cur_wake, cur_prio, cur_id}), .rd_idx(idx),
    .rd_data(sq_rd), .front(sq_front), .count(sq_count)
  );

  // Shared comparator operand selection.
  always_comb begin
    cmp_ta = cur_wake;
    cmp_tb = sq_rd[SW-1:PRIORITY_BITS+IdW];
    cmp_pa = cur_prio;
    cmp_pb = sq_rd[PRIORITY_BITS+IdW-1:IdW];
    unique case (state)
      ST_RSCAN: begin
        cmp_pa = rq_rd[PRIORITY_BITS-1:0];
        cmp_pb = cur_prio;
      end
      ST_WAKE: begin
        cmp_ta = sq_front[SW-1:PRIORITY_BITS+IdW];
        cmp_tb = now_r;
      end
      default: begin
      end
    endcase
  end

  prs_cmp #(.TICK_BITS(TICK_BITS), .PRIORITY_BITS(PRIORITY_BITS)) u_cmp (
    .tick_a(cmp_ta), .tick_b(cmp_tb), .prio_a(cmp_pa), .prio_b(cmp_pb), .res(cmp)
  );

  // Whether the scan walks on past the current entry.
  always_comb begin
    if (state == ST_RSCAN) begin
      scan_more = CntW'(idx) < rq_count && cmp.prio_ge;
    end else begin
      scan_more = CntW'(idx) < sq_count && !(cmp.tick_lt || (cmp.tick_eq && cmp.prio_ge));
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_READY:    state_next = rq_full ? ST_DONE : ST_RSCAN;
            OP_SLEEP:    state_next = sq_full ? ST_DONE : ST_SSCAN;
            OP_TICK:     state_next = ST_WAKE;
            OP_DISPATCH: state_next = ST_DONE;
          endcase
        end
      end
      ST_RSCAN: begin
        if (!scan_more) state_next = waking ? ST_WAKE : ST_DONE;
      end
      ST_SSCAN: begin
        if (!scan_more) state_next = ST_DONE;
      end
      ST_WAKE: begin
        state_next = wake_due ? ST_RSCAN : ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Queue control outputs.
  always_comb begin
    rq_ctrl = '0;
    sq_ctrl = '0;
    unique case (state)
      ST_IDLE: begin
        rq_ctrl.pop_en = accept && in_op == OP_DISPATCH && rq_count != '0;
      end
      ST_RSCAN: begin
        rq_ctrl.ins_en = !scan_more;
        sq_ctrl.pop_en = !scan_more && waking;
      end
      ST_SSCAN: begin
        sq_ctrl.ins_en = !scan_more;
      end
      default: begin
      end
    endcase
  end

  // Sequencer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Word under work and its result.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        idx         <= '0;
        cur_id      <= in_id;
        cur_prio    <= in_prio;
        cur_wake    <= in_wake;
        now_r       <= in_now;
        waking      <= 1'b0;
        res_next    <= (in_op == OP_DISPATCH && rq_count != '0) ? rq_front[RW-1:PRIORITY_BITS]
                                                                : 4'd0;
        res_valid   <= in_op == OP_DISPATCH && rq_count != '0;
        res_preempt <= in_op == OP_TICK && slice_inc >= slice_limit;
        res_status  <= (in_op == OP_READY && rq_full) || (in_op == OP_SLEEP && sq_full);
        woke        <= '0;
      end
      ST_RSCAN, ST_SSCAN: begin
        if (scan_more) idx <= idx + IdxW'(1);
        if (!scan_more && waking && state == ST_RSCAN) woke <= woke + CntW'(1);
      end
      ST_WAKE: begin
        idx      <= '0;
        waking   <= 1'b1;
        cur_id   <= sq_front[IdW-1:0];
        cur_prio <= sq_front[PRIORITY_BITS+IdW-1:IdW];
      end
      default: begin
      end
    endcase
  end

  // Slice counter and time slice register.
  always_ff @(posedge clk) begin
    if (rst) begin
      slice       <= 8'd0;
      slice_limit <= SliceReset;
    end else begin
      if (cfg_we) slice_limit <= cfg_wdata;
      if (accept && in_op == OP_TICK) begin
        slice <= slice_inc;
      end else if (accept && in_op == OP_DISPATCH) begin
        slice <= 8'd0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= {4'd0, res_status, 5'(woke), res_preempt, res_valid, res_next};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Checks.
  a_rq_bound: assert property (@(posedge clk) disable iff (rst)
    rq_count <= CntW'(MAX_THREADS)) else $error("ready queue overfilled");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_RSCAN |-> CntW'(idx) <= rq_count) else $error("scan past queue end");

  a_slice_clr: assert property (@(posedge clk) disable iff (rst)
    accept && in_op == OP_DISPATCH |=> slice == 8'd0) else $error("slice not cleared");

  a_disp_nowake: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data[4] |-> out_data[10:6] == 5'd0) else $error("dispatch with wake");

endmodule

FILE: tb/priority_ready_and_sleep_queues_top_tb.sv
// ----------------------------------------------------------------------------
// Scheduler queues testbench
// Drives ready, sleep, tick and dispatch words into the scheduler queues,
// predicts every result word with a behavioural copy of both queues and the
// slice counter, and compares each result field by field.
// ----------------------------------------------------------------------------
module priority_ready_and_sleep_queues_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prs_pkg::*;

  localparam int Depth = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;

  typedef struct packed {
    logic       status;
    logic [4:0] woke_count;
    logic       preempt;
    logic       dispatch_valid;
    logic [3:0] next_thread;
  } sched_res_t;

  typedef struct {
    logic [3:0]  id;
    logic [5:0]  prio;
    logic [31:0] wake;
  } thread_ent_t;

  // Predictor state.
  thread_ent_t ready_q[$];
  thread_ent_t sleep_q[$];
  logic [7:0]  slice_cnt;
  logic [7:0]  slice_len;

  sched_res_t expected_results[$];
  int         mismatches = 0;
  logic       stall_allowed = 1'b1;
  int         rx_hold = 0;

  always #5 clk = ~clk;

  priority_ready_and_sleep_queues_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // op, thread_id, priority_req, wake_tick, now_tick
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // next_thread, dispatch_valid, preempt, woke_count, status
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Ordered insert into the ready queue: behind every entry of equal priority.
  function automatic logic ready_enqueue(logic [3:0] id, logic [5:0] prio);
    int pos;
    thread_ent_t e;
    if (ready_q.size() >= Depth) return 1'b0;
    pos = 0;
    while (pos < ready_q.size() && ready_q[pos].prio >= prio) pos++;
    e.id = id;
    e.prio = prio;
    e.wake = '0;
    ready_q.insert(pos, e);
    return 1'b1;
  endfunction

  // Works out the result of one word and updates the predicted queues.
  function automatic sched_res_t schedule_word(op_t op, logic [3:0] id, logic [5:0] prio,
                                               logic [31:0] wake, logic [31:0] now);
    sched_res_t r;
    thread_ent_t e;
    int pos;
    r = '0;
    case (op)
      OP_READY: begin
        r.status = !ready_enqueue(id, prio);
      end
      OP_SLEEP: begin
        if (sleep_q.size() >= Depth) begin
          r.status = 1'b1;
        end else begin
          pos = 0;
          while (pos < sleep_q.size() && !(wake < sleep_q[pos].wake ||
                 (wake == sleep_q[pos].wake && prio >= sleep_q[pos].prio))) pos++;
          e.id = id;
          e.prio = prio;
          e.wake = wake;
          sleep_q.insert(pos, e);
        end
      end
      OP_TICK: begin
        if (slice_cnt != SliceMax) slice_cnt++;
        r.preempt = slice_cnt >= slice_len;
        while (sleep_q.size() > 0 && sleep_q[0].wake <= now && ready_q.size() < Depth) begin
          void'(ready_enqueue(sleep_q[0].id, sleep_q[0].prio));
          sleep_q.pop_front();
          r.woke_count++;
        end
      end
      default: begin
        if (ready_q.size() > 0) begin
          r.next_thread = ready_q[0].id;
          r.dispatch_valid = 1'b1;
          ready_q.pop_front();
        end
        slice_cnt = '0;
      end
    endcase
    return r;
  endfunction

  // Random gap: mostly short, occasionally long.
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one word and records its expected result. The valid stays high
  // after acceptance until the next gap or the next pause.
  task automatic send_word(op_t op, logic [3:0] id, logic [5:0] prio,
                           logic [31:0] wake, logic [31:0] now);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_tdata <= {4'd0, now, wake, prio, id, op};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(schedule_word(op, id, prio, wake, now));
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_slice(logic [7:0] v);
    wait_drained();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    slice_len = v;
  endtask

  // Receiver stall pattern: mostly short pauses, a few long ones.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (!stall_allowed) begin
      m_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else begin
      rx_hold = gap_len();
      m_tready <= (rx_hold == 0);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    sched_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[11:0];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %h", m_tdata);
      end else begin
        want = expected_results.pop_front();
        if (got !== want || m_tdata[15:12] !== 4'd0) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"Mismatch: expected thread %0d valid %0b preempt %0b woke %0d ",
                      "status %0b, got thread %0d valid %0b preempt %0b woke %0d ",
                      "status %0b"},
                     want.next_thread, want.dispatch_valid, want.preempt,
                     want.woke_count, want.status, got.next_thread,
                     got.dispatch_valid, got.preempt, got.woke_count, got.status);
        end
      end
    end
  end

  // Extremes of the fields, every operation, full queues and idle dispatch.
  task automatic test_directed();
    int i;
    send_word(OP_DISPATCH, 4'hF, 6'h3F, '1, '1);
    send_word(OP_READY, 4'hF, 6'h3F, '0, '0);
    send_word(OP_READY, 4'h0, 6'h00, '1, '1);
    send_word(OP_READY, 4'h5, 6'h3F, '0, '0);
    send_word(OP_SLEEP, 4'hA, 6'h00, 32'hFFFF_FFFF, '0);
    send_word(OP_SLEEP, 4'h3, 6'h3F, 32'hFFFF_FFFF, '0);
    send_word(OP_SLEEP, 4'h3, 6'h10, 32'd0, '1);
    send_word(OP_TICK, 4'hF, 6'h3F, '1, 32'd0);
    send_word(OP_TICK, 4'h0, 6'h00, '0, 32'hFFFF_FFFE);
    send_word(OP_TICK, 4'h0, 6'h00, '0, 32'hFFFF_FFFF);
    for (i = 0; i < 6; i++) send_word(OP_DISPATCH, 4'h0, 6'h00, '0, '0);
    // Fill the ready queue beyond its depth.
    for (i = 0; i < 17; i++) send_word(OP_READY, i[3:0], 6'd7, '0, '0);
    // Fill the sleep queue beyond its depth, all due at once.
    for (i = 0; i < 17; i++) send_word(OP_SLEEP, i[3:0], i[5:0], 32'd100, '0);
    // Ready queue full: nobody can wake.
    send_word(OP_TICK, 4'h0, 6'h00, '0, 32'd200);
    for (i = 0; i < 5; i++) send_word(OP_DISPATCH, 4'h0, 6'h00, '0, '0);
    send_word(OP_TICK, 4'h0, 6'h00, '0, 32'd200);
    for (i = 0; i < 30; i++) send_word(OP_DISPATCH, 4'h0, 6'h00, '0, '0);
    send_word(OP_TICK, 4'h0, 6'h00, '0, 32'd200);
  endtask

  // Slice counter saturation with the largest and smallest slice.
  task automatic test_slice(logic [7:0] len, int ticks);
    int i;
    write_slice(len);
    send_word(OP_DISPATCH, 4'h0, 6'h00, '0, '0);
    for (i = 0; i < ticks; i++) send_word(OP_TICK, 4'h0, 6'h00, '0, '0);
  endtask

  // Random scheduling traffic around a moving clock.
  task automatic test_random(int n, logic [31:0] base);
    int i, k;
    logic [31:0] now, w, t;
    logic [5:0]  p;
    now = base;
    for (i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      w = ($urandom_range(0, 9) == 0) ? $urandom() : now + $urandom_range(0, 20);
      p = ($urandom_range(0, 3) == 0) ? 6'($urandom()) : 6'($urandom_range(0, 7));
      if (k < 30) begin
        send_word(OP_READY, 4'($urandom()), p, $urandom(), $urandom());
      end else if (k < 55) begin
        send_word(OP_SLEEP, 4'($urandom()), p, w, $urandom());
      end else if (k < 78) begin
        now = now + $urandom_range(0, 6);
        t = ($urandom_range(0, 30) == 0) ? $urandom() : now;
        send_word(OP_TICK, 4'($urandom()), 6'($urandom()), $urandom(), t);
      end else begin
        send_word(OP_DISPATCH, 4'($urandom()), 6'($urandom()), $urandom(), $urandom());
      end
    end
  endtask

  initial begin
    slice_len = SliceReset;
    slice_cnt = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_slice(8'd255, 260);
    test_slice(8'd1, 3);
    test_slice(8'd0, 3);
    write_slice(8'd3);
    test_random(600, 32'd1000);
    // Hold off until every result is back, without receiver stalls.
    stall_allowed = 1'b0;
    wait_drained();
    stall_allowed = 1'b1;
    write_slice(8'd200);
    test_random(500, 32'hFFFF_FF00);
    write_slice(8'd2);
    test_random(450, 32'h8000_0000);
    wait_drained();
    if (mismatches == 0 && expected_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog.
  initial begin
    #100ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
